>>> design/rectangle_point_query_macros.svh
// Assertion macros for the checker file.
`ifndef RECTANGLE_POINT_QUERY_MACROS_SVH
`define RECTANGLE_POINT_QUERY_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define RPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define RPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that also holds across reset.
`define RPQ_ASSERT_ALW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/rpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpq_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_point;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] x_max;
        logic signed [31:0] y_min;
        logic signed [31:0] y_max;
    } t_rect;

    // Read and write port control from the sequencer to the store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;
    localparam int IDX_W       = 6;

endpackage

`default_nettype wire

>>> design/rpq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rpq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                i_clk,
    input  wire rpq_pkg::t_store_ctl i_ctl,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire rpq_pkg::t_point     i_wr_data,
    input  wire logic [AW-1:0]       i_rd_addr,
    output rpq_pkg::t_point          o_rd_data
);

    rpq_pkg::t_point r_mem [DEPTH];
    rpq_pkg::t_point r_rd_data;

    // Write one point per load request
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold the data while the scan is paused
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/rpq_match.sv
`timescale 1ns / 1ps
`default_nettype none

module rpq_match (
    input  wire rpq_pkg::t_point i_point,
    input  wire rpq_pkg::t_rect  i_rect,
    output logic                 o_hit
);

    // Inclusive bounds test; an inverted range never hits
    always_comb begin
        o_hit = (i_point.x >= i_rect.x_min) && (i_point.x <= i_rect.x_max) &&
                (i_point.y >= i_rect.y_min) && (i_point.y <= i_rect.y_max);
    end

endmodule

`default_nettype wire

>>> design/rpq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rpq_seq #(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_kind,
    input  wire logic signed [31:0]  i_point_x,
    input  wire logic signed [31:0]  i_point_y,
    input  wire logic signed [31:0]  i_x_min,
    input  wire logic signed [31:0]  i_x_max,
    input  wire logic signed [31:0]  i_y_min,
    input  wire logic signed [31:0]  i_y_max,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [5:0]               o_point_index,
    output logic                     o_found,
    output logic                     o_last,
    // store and compare unit
    output rpq_pkg::t_store_ctl      o_store_ctl,
    output logic [AW-1:0]            o_wr_addr,
    output rpq_pkg::t_point          o_wr_data,
    output logic [AW-1:0]            o_rd_addr,
    output rpq_pkg::t_rect           o_rect,
    input  wire logic                i_hit
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    rpq_pkg::t_state           r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_addr, n_addr;
    logic                      r_dv, n_dv;
    logic [AW-1:0]             r_dv_idx, n_dv_idx;
    logic                      r_pend, n_pend;
    logic [AW-1:0]             r_pend_idx, n_pend_idx;
    logic [rpq_pkg::RES_W-1:0] r_nres, n_nres;
    rpq_pkg::t_rect            r_rect, n_rect;
    logic                      r_o_valid, n_o_valid;
    logic [5:0]                r_o_idx, n_o_idx;
    logic                      r_o_found, n_o_found;
    logic                      r_o_last, n_o_last;

    logic                      w_out_free;
    logic                      w_hit;
    logic [AW+rpq_pkg::IDX_W-1:0] w_idx_ext;

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_hit      = r_dv && i_hit;
    assign w_idx_ext  = {{rpq_pkg::IDX_W{1'b0}}, r_pend_idx};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rpq_pkg::ST_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_dv_idx   <= n_dv_idx;
        r_pend_idx <= n_pend_idx;
        r_nres     <= n_nres;
        r_rect     <= n_rect;
        r_o_idx    <= n_o_idx;
        r_o_found  <= n_o_found;
        r_o_last   <= n_o_last;
    end

    // Next state, scan step and result register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_dv        = r_dv;
        n_dv_idx    = r_dv_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_nres      = r_nres;
        n_rect      = r_rect;
        n_o_valid   = r_o_valid && i_stall;
        n_o_idx     = r_o_idx;
        n_o_found   = r_o_found;
        n_o_last    = r_o_last;
        o_store_ctl = '0;
        o_wr_addr   = r_count[AW-1:0];
        o_wr_data   = '{x: i_point_x, y: i_point_y};
        o_rd_addr   = r_addr[AW-1:0];

        case (r_state)
            rpq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (rpq_pkg::t_kind'(i_kind))
                        rpq_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        rpq_pkg::KIND_LOAD: begin
                            // drop the point when the store is full
                            if (r_count != CW'(MAX_POINTS)) begin
                                o_store_ctl.wr_en = 1'b1;
                                n_count           = r_count + CW'(1);
                            end
                        end
                        rpq_pkg::KIND_QUERY: begin
                            n_rect  = '{x_min: i_x_min, x_max: i_x_max,
                                        y_min: i_y_min, y_max: i_y_max};
                            n_addr  = '0;
                            n_dv    = 1'b0;
                            n_pend  = 1'b0;
                            n_nres  = '0;
                            n_state = rpq_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rpq_pkg::ST_SCAN: begin
                // pause when a held hit must go out and the result register is busy
                if (!(w_hit && r_pend && !w_out_free)) begin
                    if (w_hit && r_pend) begin
                        n_o_valid = 1'b1;
                        n_o_idx   = w_idx_ext[rpq_pkg::IDX_W-1:0];
                        n_o_found = 1'b1;
                        n_o_last  = 1'b0;
                    end
                    if (w_hit) begin
                        n_pend     = 1'b1;
                        n_pend_idx = r_dv_idx;
                        n_nres     = r_nres + rpq_pkg::RES_W'(1);
                    end
                    if (w_hit && r_nres == rpq_pkg::RES_W'(rpq_pkg::MAX_RESULTS - 1)) begin
                        // result cap reached: stop the scan
                        n_dv    = 1'b0;
                        n_state = rpq_pkg::ST_FLUSH;
                    end else if (r_addr < r_count) begin
                        o_store_ctl.rd_en = 1'b1;
                        n_addr            = r_addr + CW'(1);
                        n_dv              = 1'b1;
                        n_dv_idx          = r_addr[AW-1:0];
                    end else begin
                        n_dv    = 1'b0;
                        n_state = rpq_pkg::ST_FLUSH;
                    end
                end
            end
            rpq_pkg::ST_FLUSH: begin
                // emit the held hit as last, or the no-hit result
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_pend ? w_idx_ext[rpq_pkg::IDX_W-1:0] : '0;
                    n_o_found = r_pend;
                    n_o_last  = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = rpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != rpq_pkg::ST_IDLE);
    assign o_rect        = r_rect;
    assign o_valid       = r_o_valid;
    assign o_point_index = r_o_idx;
    assign o_found       = r_o_found;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

>>> design/rectangle_point_query.sv
// Channel   | Direction | Handshake          | Payload
// request   | in        | i_valid / o_stall  | i_kind, i_point_x, i_point_y,
//           |           |                    | i_x_min, i_x_max, i_y_min, i_y_max
// result    | out       | o_valid / i_stall  | o_point_index, o_found, o_last
//
// Clear and load requests leave the sequencer idle, so o_stall stays low for them.
// A query scans the stored points in order, pausing only as noted below:
// the store's single read port and the shared compare unit test one point per cycle.
// Reset (synchronous, active low) empties the store; point data are not cleared.
// A stalled result pauses the scan only when another hit must go out.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_point_query #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_x_min,
    input  wire logic signed [31:0] i_x_max,
    input  wire logic signed [31:0] i_y_min,
    input  wire logic signed [31:0] i_y_max,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [5:0]              o_point_index,
    output logic                    o_found,
    output logic                    o_last
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    rpq_pkg::t_store_ctl w_store_ctl;
    logic [AW-1:0]       w_wr_addr;
    rpq_pkg::t_point     w_wr_data;
    logic [AW-1:0]       w_rd_addr;
    rpq_pkg::t_point     w_rd_data;
    rpq_pkg::t_rect      w_rect;
    logic                w_hit;

    rpq_seq #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_x_min       (i_x_min),
        .i_x_max       (i_x_max),
        .i_y_min       (i_y_min),
        .i_y_max       (i_y_max),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_index (o_point_index),
        .o_found       (o_found),
        .o_last        (o_last),
        .o_store_ctl   (w_store_ctl),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_addr     (w_rd_addr),
        .o_rect        (w_rect),
        .i_hit         (w_hit)
    );

    rpq_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_store_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    rpq_match u_match (
        .i_point (w_rd_data),
        .i_rect  (w_rect),
        .o_hit   (w_hit)
    );

endmodule

`default_nettype wire

>>> design/rpq_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rectangle_point_query_macros.svh"

module rpq_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [5:0] o_point_index,
    input wire logic       o_found,
    input wire logic       o_last
);

    // Hold a stalled result
    `RPQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_point_index, o_found, o_last}), "stalled result changed")

    // A no-hit result is always the last and carries index zero
    `RPQ_ASSERT_IMP(a_nohit, i_clk, i_rst_n, o_valid && !o_found, o_last && (o_point_index == 6'd0), "bad no-hit result")

    // Stay busy while a query still has results to come
    `RPQ_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid && !o_last, o_stall, "idle with query open")

    // Drop any result on reset
    `RPQ_ASSERT_ALW(a_rst, i_clk, $past(i_rst_n) == 1'b0, !o_valid, "result after reset")

endmodule

bind rectangle_point_query rpq_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_point_index (o_point_index),
    .o_found       (o_found),
    .o_last        (o_last)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int N_SLOTS     = 64;
    localparam int RAND_ITEMS  = 110;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 19;

    // Code that the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [1:0]                kind;
        logic signed [31:0]        px;
        logic signed [31:0]        py;
        logic signed [31:0]        xlo;
        logic signed [31:0]        xhi;
        logic signed [31:0]        ylo;
        logic signed [31:0]        yhi;
        bit                        typed;
        logic [rpq_pkg::IDX_W-1:0] t_idx;
        bit                        t_found;
    } t_request;

    typedef struct {
        logic [rpq_pkg::IDX_W-1:0] idx;
        logic                      found;
        logic                      last;
    } t_hit;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               i_stall   = 1'b0;
    logic [1:0]         i_kind    = rpq_pkg::KIND_CLEAR;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_x_min   = '0;
    logic signed [31:0] i_x_max   = '0;
    logic signed [31:0] i_y_min   = '0;
    logic signed [31:0] i_y_max   = '0;
    logic               o_stall;
    logic               o_valid;
    logic [5:0]         o_point_index;
    logic               o_found;
    logic               o_last;

    // Mirror of the point store
    logic signed [31:0] pt_x [N_SLOTS];
    logic signed [31:0] pt_y [N_SLOTS];
    int                 pt_cnt = 0;

    t_request dir_tab [N_DIR];
    t_request req_q [$];
    t_request cur;
    t_hit     due_results [$];

    int  n_total    = 0;
    int  acc_cnt    = 0;
    int  hold_at    = 0;
    int  n_query    = 0;
    int  n_dropped  = 0;
    int  n_checked  = 0;
    int  burst      = 0;
    int  max_burst  = 0;
    int  err_cnt    = 0;
    int  cyc        = 0;
    logic hold_stall = 1'b0;
    logic calm;

    rectangle_point_query u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_x_min       (i_x_min),
        .i_x_max       (i_x_max),
        .i_y_min       (i_y_min),
        .i_y_max       (i_y_max),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_index (o_point_index),
        .o_found       (o_found),
        .o_last        (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Build request items; unused fields carry random noise
    function automatic t_request load_req(logic signed [31:0] x, logic signed [31:0] y);
        t_request r;
        r = '{kind: rpq_pkg::KIND_LOAD, px: x, py: y, xlo: $urandom, xhi: $urandom,
              ylo: $urandom, yhi: $urandom, typed: 0, t_idx: '0, t_found: 0};
        return r;
    endfunction

    function automatic t_request query_req(logic signed [31:0] xlo, logic signed [31:0] xhi,
                                           logic signed [31:0] ylo, logic signed [31:0] yhi,
                                           bit typed, int idx, bit found);
        t_request r;
        r = '{kind: rpq_pkg::KIND_QUERY, px: $urandom, py: $urandom, xlo: xlo, xhi: xhi,
              ylo: ylo, yhi: yhi, typed: typed, t_idx: rpq_pkg::IDX_W'(idx),
              t_found: found};
        return r;
    endfunction

    function automatic t_request bare_req(logic [1:0] kind);
        t_request r;
        r = '{kind: kind, px: $urandom, py: $urandom, xlo: $urandom, xhi: $urandom,
              ylo: $urandom, yhi: $urandom, typed: 0, t_idx: '0, t_found: 0};
        return r;
    endfunction

    // Mostly a small cluster so that queries hit, sometimes extremes or anything
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 7)) - 4;
        endcase
    endfunction

    function automatic t_request rand_query();
        logic signed [31:0] a, b, c, d, t;
        case ($urandom_range(0, 5))
            0: begin
                a = S_MIN; b = S_MAX; c = S_MIN; d = S_MAX;
            end
            1: begin
                a = $urandom; b = $urandom; c = $urandom; d = $urandom;
            end
            2: begin
                a = rand_coord(); b = S_MAX; c = S_MIN; d = rand_coord();
            end
            default: begin
                a = int'($urandom_range(0, 8)) - 5;
                b = a + int'($urandom_range(0, 4));
                c = int'($urandom_range(0, 8)) - 5;
                d = c + int'($urandom_range(0, 4));
                if ($urandom_range(0, 9) == 0) begin
                    t = a; a = b + 1; b = t;
                end
            end
        endcase
        return query_req(a, b, c, d, 0, 0, 0);
    endfunction

    // Apply an accepted request to the mirror and queue what it should produce
    function automatic void absorb_request(t_request r);
        t_hit hits [$];
        t_hit h;
        case (r.kind)
            rpq_pkg::KIND_CLEAR: pt_cnt = 0;
            rpq_pkg::KIND_LOAD: begin
                if (pt_cnt < N_SLOTS) begin
                    pt_x[pt_cnt] = r.px;
                    pt_y[pt_cnt] = r.py;
                    pt_cnt++;
                end else begin
                    n_dropped++;
                end
            end
            rpq_pkg::KIND_QUERY: begin
                n_query++;
                for (int i = 0; i < pt_cnt; i++) begin
                    if (pt_x[i] >= r.xlo && pt_x[i] <= r.xhi &&
                        pt_y[i] >= r.ylo && pt_y[i] <= r.yhi &&
                        hits.size() < rpq_pkg::MAX_RESULTS) begin
                        h.idx   = rpq_pkg::IDX_W'(i);
                        h.found = 1'b1;
                        h.last  = 1'b0;
                        hits    = {hits, h};
                    end
                end
                if (hits.size() == 0) begin
                    h.idx   = '0;
                    h.found = 1'b0;
                    h.last  = 1'b1;
                    hits    = {hits, h};
                end else begin
                    hits[hits.size() - 1].last = 1'b1;
                end
                if (r.typed) begin
                    h.idx       = r.t_idx;
                    h.found     = r.t_found;
                    h.last      = 1'b1;
                    due_results = {due_results, h};
                end else begin
                    due_results = {due_results, hits};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_result(string what, t_hit want);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("[%0t] %s: expected idx %0d found %0b last %0b, got idx %0d found %0b last %0b",
                     $realtime, what, want.idx, want.found, want.last,
                     o_point_index, o_found, o_last);
        end
    endtask

    // Stimulus: directed table, then fill past capacity, then random sequences
    initial begin
        int n_rand;
        int nl;
        int nq;

        dir_tab[0]  = query_req(S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 0);
        dir_tab[1]  = load_req(S_MIN, S_MIN);
        dir_tab[2]  = load_req(S_MAX, S_MAX);
        dir_tab[3]  = load_req(0, 0);
        dir_tab[4]  = load_req(-1, 1);
        dir_tab[5]  = query_req(S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 0);
        dir_tab[6]  = query_req(S_MAX, S_MAX, S_MAX, S_MAX, 1, 1, 1);
        dir_tab[7]  = query_req(S_MIN, S_MIN, S_MIN, S_MIN, 1, 0, 1);
        dir_tab[8]  = query_req(1, 0, S_MIN, S_MAX, 1, 0, 0);
        dir_tab[9]  = query_req(S_MIN, S_MAX, 0, -1, 1, 0, 0);
        dir_tab[10] = query_req(-1, 0, 0, 1, 0, 0, 0);
        dir_tab[11] = bare_req(KIND_UNUSED);
        dir_tab[12] = query_req(0, 0, 0, 0, 1, 2, 1);
        dir_tab[13] = query_req(S_MAX, S_MAX, S_MIN, S_MIN, 1, 0, 0);
        dir_tab[14] = bare_req(rpq_pkg::KIND_CLEAR);
        dir_tab[15] = query_req(S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 0);
        dir_tab[16] = load_req(5, -5);
        dir_tab[17] = query_req(S_MIN, S_MAX, S_MIN, S_MAX, 1, 0, 1);
        dir_tab[18] = bare_req(rpq_pkg::KIND_CLEAR);
        foreach (dir_tab[i]) req_q = {req_q, dir_tab[i]};

        // Fill the store past capacity, then stall results while queries pile up
        req_q = {req_q, bare_req(rpq_pkg::KIND_CLEAR)};
        for (int i = 0; i < N_SLOTS + 2; i++) begin
            req_q = {req_q, load_req(int'($urandom_range(0, 7)) - 4,
                                     int'($urandom_range(0, 7)) - 4)};
        end
        hold_at = req_q.size();
        req_q = {req_q, query_req(S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 0)};
        repeat (3) req_q = {req_q, rand_query()};
        n_rand = N_SLOTS + 7;

        while (n_rand < RAND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                req_q = {req_q, bare_req(rpq_pkg::KIND_CLEAR)};
                n_rand++;
            end
            nl = $urandom_range(0, 10);
            repeat (nl) req_q = {req_q, load_req(rand_coord(), rand_coord())};
            nq = $urandom_range(1, 4);
            repeat (nq) req_q = {req_q, rand_query()};
            n_rand += nl + nq;
            if ($urandom_range(0, 4) == 0) req_q = {req_q, bare_req(KIND_UNUSED)};
        end
        n_total = req_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (acc_cnt == n_total);
        wait (due_results.size() == 0);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d requests: %0d queries, %0d loads dropped on a full store.",
                 n_total, n_query, n_dropped);
        $display("Checked %0d results; longest hit list %0d.", n_checked, max_burst);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Advance the cycle count; both sides run without gaps in part of each window
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end
    assign calm = (cyc % 1200) >= 900;

    // Drive requests, holding each one until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                absorb_request(cur);
                acc_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                    cur = req_q.pop_front();
                    i_kind    <= cur.kind;
                    i_point_x <= cur.px;
                    i_point_y <= cur.py;
                    i_x_min   <= cur.xlo;
                    i_x_max   <= cur.xhi;
                    i_y_min   <= cur.ylo;
                    i_y_max   <= cur.yhi;
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Hold off the result side once the store is full
    initial begin
        wait (i_rst_n && hold_at != 0 && acc_cnt >= hold_at);
        @(posedge i_clk);
        hold_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_stall <= 1'b0;
    end

    // Stall results at random outside calm windows, and throughout the hold
    always @(posedge i_clk) begin
        i_stall <= hold_stall || (!calm && $urandom_range(0, 99) < 25);
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin : chk
        t_hit want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            burst++;
            if (o_last) begin
                if (burst > max_burst) max_burst = burst;
                burst = 0;
            end
            if (due_results.size() == 0) begin
                want = '{idx: '0, found: 1'b0, last: 1'b0};
                flag_result("result with nothing pending", want);
            end else begin
                want = due_results.pop_front();
                if (o_point_index !== want.idx || o_found !== want.found ||
                    o_last !== want.last) begin
                    flag_result("result mismatch", want);
                end
            end
        end
    end

endmodule

>>> files.f
+incdir+design
design/rpq_pkg.sv
design/rpq_store.sv
design/rpq_match.sv
design/rpq_seq.sv
design/rectangle_point_query.sv
design/rpq_check.sv
sim/tb_top.sv
